// File: hw/rtl/mi3_pkg.sv
// Shared widths and constants for the 3x3 matrix inverse datapath.
// No dependencies; the files that use it refer to it by scoped names.
package mi3_pkg;

  parameter int unsigned ELEMENT_WIDTH_DEF = 16;
  parameter int unsigned INV_WIDTH         = 32;
  parameter int unsigned DET_OUT_WIDTH     = 49;
  parameter int unsigned FRAC_SHIFT        = 24;
  parameter int unsigned SAT_SHIFT         = INV_WIDTH - FRAC_SHIFT;
  parameter int unsigned FRONT_STAGES      = 4;
  parameter int unsigned MATRIX_ELEMS      = 9;
  parameter int unsigned WORD_LIMIT        = 64;

  // Exact width of a cofactor, capped at the 64-bit wrap of the arithmetic.
  function automatic int unsigned adj_width(int unsigned w);
    return (2 * w + 1 > WORD_LIMIT) ? WORD_LIMIT : 2 * w + 1;
  endfunction

  // Exact width of the determinant, capped likewise.
  function automatic int unsigned det_width(int unsigned w);
    return (3 * w + 3 > WORD_LIMIT) ? WORD_LIMIT : 3 * w + 3;
  endfunction

endpackage

// File: hw/rtl/mi3_in_if.sv
// Input channel: one beat carries a full 3x3 matrix, row-major.
// Depends on nothing; width set by the element width parameter.
interface mi3_in_if #(
  parameter int unsigned ELEMENT_WIDTH = 16
);
  logic                            valid;
  logic                            ready;
  logic signed [ELEMENT_WIDTH-1:0] m00, m01, m02;
  logic signed [ELEMENT_WIDTH-1:0] m10, m11, m12;
  logic signed [ELEMENT_WIDTH-1:0] m20, m21, m22;

  modport source (output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                  input ready);
  modport sink   (input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                  output ready);
endinterface

// File: hw/rtl/mi3_out_if.sv
// Output channel: one beat carries the inverse, determinant and singular flag.
// Depends on nothing; field widths are fixed.
interface mi3_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] inv00, inv01, inv02;
  logic signed [31:0] inv10, inv11, inv12;
  logic signed [31:0] inv20, inv21, inv22;
  logic signed [48:0] determinant;
  logic               singular;

  modport source (output valid, inv00, inv01, inv02, inv10, inv11, inv12,
                  inv20, inv21, inv22, determinant, singular,
                  input ready);
  modport sink   (input valid, inv00, inv01, inv02, inv10, inv11, inv12,
                  inv20, inv21, inv22, determinant, singular,
                  output ready);
endinterface

// File: hw/rtl/mi3_ctrl.sv
// Valid tracking and per-stage load enables for the whole pipeline.
// Uses no package items; stage count handed down from the top level.
module mi3_ctrl #(
  parameter int unsigned NUM_STAGES = 38
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  out_ready_i,
  output logic [NUM_STAGES-1:0] en_o,
  output logic                  in_ready_o,
  output logic                  out_valid_o
);

  logic [NUM_STAGES-1:0] v_q;
  logic [NUM_STAGES-1:0] en_d;

  // A stage loads when empty or when its contents move on.
  always_comb begin
    en_d[NUM_STAGES-1] = !v_q[NUM_STAGES-1] || out_ready_i;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      en_d[k] = !v_q[k] || en_d[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en_d[0]) begin
        v_q[0] <= in_valid_i;
      end
      for (int k = 1; k < NUM_STAGES; k++) begin
        if (en_d[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  assign en_o        = en_d;
  assign in_ready_o  = en_d[0];
  assign out_valid_o = v_q[NUM_STAGES-1];

endmodule

// File: hw/rtl/mi3_cofactor.sv
// Front end: cofactor products, adjugate, and first-row determinant expansion.
// Depends on mi3_pkg for element count and front-end stage count.
module mi3_cofactor #(
  parameter int unsigned ELEMENT_WIDTH = 16,
  parameter int unsigned AW            = 33,
  parameter int unsigned DW            = 51
) (
  input  logic                                                 clk_i,
  input  logic [mi3_pkg::FRONT_STAGES-1:0]                     en_i,
  input  logic [mi3_pkg::MATRIX_ELEMS-1:0][ELEMENT_WIDTH-1:0]  elem_i,
  output logic [mi3_pkg::MATRIX_ELEMS-1:0][AW-1:0]             adj_o,
  output logic signed [DW-1:0]                                 det_o
);

  localparam int unsigned NE = mi3_pkg::MATRIX_ELEMS;
  localparam int unsigned PW = 2 * ELEMENT_WIDTH;

  // adj[j] = x[IA]*x[IB] - x[IC]*x[ID]
  localparam int unsigned IA [NE] = '{4, 2, 1, 5, 0, 3, 3, 6, 0};
  localparam int unsigned IB [NE] = '{8, 7, 5, 6, 8, 2, 7, 1, 4};
  localparam int unsigned IC [NE] = '{7, 1, 2, 3, 2, 0, 6, 0, 3};
  localparam int unsigned ID [NE] = '{5, 8, 4, 8, 6, 5, 4, 7, 1};

  logic signed [ELEMENT_WIDTH-1:0] x      [NE];
  logic signed [PW-1:0]            pa_q   [NE];
  logic signed [PW-1:0]            pb_q   [NE];
  logic signed [ELEMENT_WIDTH-1:0] row0_q [3];
  logic signed [ELEMENT_WIDTH-1:0] row1_q [3];
  logic signed [AW-1:0]            adj1_q [NE];
  logic signed [AW-1:0]            adj2_q [NE];
  logic signed [AW-1:0]            adj3_q [NE];
  logic signed [DW-1:0]            dp_q   [3];
  logic signed [DW-1:0]            det_q;
  logic signed [PW:0]              diff   [NE];

  always_comb begin
    for (int j = 0; j < NE; j++) begin
      x[j]    = elem_i[j];
      diff[j] = {pa_q[j][PW-1], pa_q[j]} - {pb_q[j][PW-1], pb_q[j]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      for (int j = 0; j < NE; j++) begin
        pa_q[j] <= x[IA[j]] * x[IB[j]];
        pb_q[j] <= x[IC[j]] * x[ID[j]];
      end
      for (int j = 0; j < 3; j++) begin
        row0_q[j] <= x[j];
      end
    end
    if (en_i[1]) begin
      for (int j = 0; j < NE; j++) begin
        adj1_q[j] <= diff[j][AW-1:0];
      end
      row1_q <= row0_q;
    end
    if (en_i[2]) begin
      adj2_q   <= adj1_q;
      dp_q[0]  <= row1_q[0] * adj1_q[0];
      dp_q[1]  <= row1_q[1] * adj1_q[3];
      dp_q[2]  <= row1_q[2] * adj1_q[6];
    end
    if (en_i[3]) begin
      adj3_q <= adj2_q;
      det_q  <= dp_q[0] + dp_q[1] + dp_q[2];
    end
  end

  always_comb begin
    for (int j = 0; j < NE; j++) begin
      adj_o[j] = adj3_q[j];
    end
  end

  assign det_o = det_q;

endmodule

// File: hw/rtl/mi3_div_lane.sv
// One divider lane: pipelined restoring division of a cofactor by the
// determinant, one quotient bit per stage, then sign and saturation.
// Depends on mi3_pkg for quotient width and scaling shift.
module mi3_div_lane #(
  parameter int unsigned AW = 33,
  parameter int unsigned DW = 51
) (
  input  logic                             clk_i,
  input  logic [mi3_pkg::INV_WIDTH:0]      en_i,
  input  logic signed [AW-1:0]             adj_i,
  input  logic signed [DW-1:0]             det_i,
  output logic [mi3_pkg::INV_WIDTH-1:0]    quot_o
);

  localparam int unsigned QB = mi3_pkg::INV_WIDTH;
  localparam int unsigned SH = mi3_pkg::SAT_SHIFT;
  localparam int unsigned RW = DW + SH;
  localparam logic [QB-1:0] NEG_LIM = {1'b1, {(QB-1){1'b0}}};
  localparam logic [QB-1:0] POS_LIM = {1'b0, {(QB-1){1'b1}}};

  typedef struct packed {
    logic neg;
    logic sat;
    logic zero;
  } flags_t;

  logic [RW-1:0] rem_q [QB];
  logic [RW-1:0] den_q [QB];
  logic [QB-1:0] quo_q [QB+1];
  flags_t        flg_q [QB+1];

  logic [AW-1:0] num_mag;
  logic [DW-1:0] den_mag;
  logic [RW-1:0] num_ext;
  logic [RW-1:0] den_sh;
  flags_t        flg_d;

  always_comb begin
    num_mag   = adj_i[AW-1] ? (~adj_i + AW'(1)) : adj_i;
    den_mag   = det_i[DW-1] ? (~det_i + DW'(1)) : det_i;
    num_ext   = RW'(num_mag);
    den_sh    = {den_mag, {SH{1'b0}}};
    flg_d.neg  = adj_i[AW-1] ^ det_i[DW-1];
    flg_d.sat  = num_ext >= den_sh;
    flg_d.zero = det_i == '0;
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      rem_q[0] <= num_ext;
      den_q[0] <= den_sh;
      quo_q[0] <= '0;
      flg_q[0] <= flg_d;
    end
  end

  for (genvar s = 0; s < QB; s++) begin : g_step
    logic [RW:0] dbl;
    logic        ge;

    always_comb begin
      dbl = {rem_q[s], 1'b0};
      ge  = dbl >= {1'b0, den_q[s]};
    end

    always_ff @(posedge clk_i) begin
      if (en_i[s+1]) begin
        quo_q[s+1] <= {quo_q[s][QB-2:0], ge};
        flg_q[s+1] <= flg_q[s];
      end
    end

    if (s < QB - 1) begin : g_rem
      always_ff @(posedge clk_i) begin
        if (en_i[s+1]) begin
          rem_q[s+1] <= ge ? RW'(dbl - {1'b0, den_q[s]}) : RW'(dbl);
          den_q[s+1] <= den_q[s];
        end
      end
    end
  end

  always_comb begin
    if (flg_q[QB].zero) begin
      quot_o = '0;
    end else if (flg_q[QB].neg) begin
      quot_o = (flg_q[QB].sat || quo_q[QB] > NEG_LIM) ? NEG_LIM : (~quo_q[QB] + QB'(1));
    end else begin
      quot_o = (flg_q[QB].sat || quo_q[QB][QB-1]) ? POS_LIM : quo_q[QB];
    end
  end

endmodule

// File: hw/rtl/matrix_inverse_3x3.sv
// 3x3 matrix inverse by adjugate over determinant.
// Channels: in_i (sink) takes one matrix of nine signed elements per beat,
// row-major; out_o (source) gives nine signed Q8.24 inverse elements, the
// Q49.0 determinant and a singular flag per beat.
// Throughput: one matrix per cycle while out_o.ready is high, set by the nine
// divider lanes that each resolve one quotient bit per stage.
// Pipeline from input beat to output valid: four cofactor and
// determinant stages, one divider set-up stage, 32 quotient-bit stages and
// the output register.
// A zero determinant gives all-zero elements with singular raised.
// Reset empties every stage; in_i.ready is high straight after reset.
// When out_o.ready is low the result holds and earlier stages keep filling
// their empty slots; in_i.ready drops only once every stage is occupied.
// Depends on mi3_pkg, mi3_in_if, mi3_out_if, mi3_ctrl, mi3_cofactor and
// mi3_div_lane.
module matrix_inverse_3x3 #(
  parameter int unsigned ELEMENT_WIDTH = mi3_pkg::ELEMENT_WIDTH_DEF
) (
  input logic      clk_i,
  input logic      rst_ni,
  mi3_in_if.sink   in_i,
  mi3_out_if.source out_o
);

  localparam int unsigned NE    = mi3_pkg::MATRIX_ELEMS;
  localparam int unsigned QB    = mi3_pkg::INV_WIDTH;
  localparam int unsigned FS    = mi3_pkg::FRONT_STAGES;
  localparam int unsigned DOW   = mi3_pkg::DET_OUT_WIDTH;
  localparam int unsigned AW    = mi3_pkg::adj_width(ELEMENT_WIDTH);
  localparam int unsigned DW    = mi3_pkg::det_width(ELEMENT_WIDTH);
  localparam int unsigned NSTG  = FS + QB + 2;

  logic [NSTG-1:0]                     en;
  logic                                out_valid;
  logic [NE-1:0][ELEMENT_WIDTH-1:0]    elem;
  logic [NE-1:0][AW-1:0]               adj;
  logic signed [DW-1:0]                det;
  logic [QB-1:0]                       quot   [NE];
  logic signed [DOW-1:0]               detp_q [QB+1];
  logic                                sing_q [QB+1];
  logic [QB-1:0]                       inv_q  [NE];
  logic signed [DOW-1:0]               det_out_q;
  logic                                sing_out_q;

  assign elem = {in_i.m22, in_i.m21, in_i.m20, in_i.m12, in_i.m11, in_i.m10,
                 in_i.m02, in_i.m01, in_i.m00};

  mi3_ctrl #(
    .NUM_STAGES (NSTG)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .out_ready_i (out_o.ready),
    .en_o        (en),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_valid)
  );

  mi3_cofactor #(
    .ELEMENT_WIDTH (ELEMENT_WIDTH),
    .AW            (AW),
    .DW            (DW)
  ) u_cofactor (
    .clk_i  (clk_i),
    .en_i   (en[FS-1:0]),
    .elem_i (elem),
    .adj_o  (adj),
    .det_o  (det)
  );

  for (genvar j = 0; j < NE; j++) begin : g_lane
    mi3_div_lane #(
      .AW (AW),
      .DW (DW)
    ) u_lane (
      .clk_i  (clk_i),
      .en_i   (en[FS+QB:FS]),
      .adj_i  (adj[j]),
      .det_i  (det),
      .quot_o (quot[j])
    );
  end

  // Carry determinant and singular flag alongside the lanes.
  always_ff @(posedge clk_i) begin
    if (en[FS]) begin
      detp_q[0] <= DOW'(det);
      sing_q[0] <= det == '0;
    end
    for (int k = 1; k <= QB; k++) begin
      if (en[FS+k]) begin
        detp_q[k] <= detp_q[k-1];
        sing_q[k] <= sing_q[k-1];
      end
    end
    if (en[NSTG-1]) begin
      inv_q      <= quot;
      det_out_q  <= sing_q[QB] ? '0 : detp_q[QB];
      sing_out_q <= sing_q[QB];
    end
  end

  assign out_o.valid       = out_valid;
  assign out_o.inv00       = inv_q[0];
  assign out_o.inv01       = inv_q[1];
  assign out_o.inv02       = inv_q[2];
  assign out_o.inv10       = inv_q[3];
  assign out_o.inv11       = inv_q[4];
  assign out_o.inv12       = inv_q[5];
  assign out_o.inv20       = inv_q[6];
  assign out_o.inv21       = inv_q[7];
  assign out_o.inv22       = inv_q[8];
  assign out_o.determinant = det_out_q;
  assign out_o.singular    = sing_out_q;

`ifndef SYNTHESIS
  a_singular_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.singular |->
      out_o.inv00 == 0 && out_o.inv01 == 0 && out_o.inv02 == 0 &&
      out_o.inv10 == 0 && out_o.inv11 == 0 && out_o.inv12 == 0 &&
      out_o.inv20 == 0 && out_o.inv21 == 0 && out_o.inv22 == 0 &&
      out_o.determinant == 0)
    else $error("singular beat with non-zero payload");

  a_stall_only_when_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> out_o.valid && !out_o.ready)
    else $error("input held off while output not stalled");

  a_out_after_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.ready |=> out_o.valid)
    else $error("output beat dropped during stall");
`endif

endmodule

// File: dv/tb_chan_if.sv
`timescale 1ns / 100ps
// Testbench-side note: the block's own interfaces mi3_in_if and mi3_out_if
// are reused directly; this file holds the shared matrix and result types.
// Depends on nothing.
package tb_mi3_types_pkg;
  typedef struct {
    logic signed [15:0] m [9];
  } matrix_t;

  typedef struct {
    logic signed [31:0] inv [9];
    logic signed [48:0] det;
    logic               sing;
  } inverse_t;
endpackage

// File: dv/tb_top.sv
`timescale 1ns / 100ps
// Testbench for matrix_inverse_3x3: drives matrices through mi3_in_if and checks
// each inverse, determinant and singular flag on mi3_out_if against a predictor.
// Depends on mi3_pkg, mi3_in_if, mi3_out_if, tb_mi3_types_pkg and the block.
module tb_top;

  localparam int unsigned LATENCY = 38;
  localparam longint CYCLE_LIMIT = 400000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  mi3_in_if #(.ELEMENT_WIDTH(16)) in_ch ();
  mi3_out_if out_ch ();

  tb_mi3_types_pkg::inverse_t expected_q[$];
  int       n_errors = 0;
  bit       in_idle_en = 1'b1;
  bit       out_stall_en = 1'b1;
  longint   cycles = 0;

  matrix_inverse_3x3 #(.ELEMENT_WIDTH(16)) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  always #2 clk_i = ~clk_i;

  function automatic logic [31:0] quotient_sat(logic signed [63:0] num,
                                               logic signed [63:0] den);
    logic        neg;
    logic [63:0] n, d, q, r;
    logic [127:0] wide;
    neg = num[63] ^ den[63];
    n = num[63] ? -num : num;
    d = den[63] ? -den : den;
    wide = {64'd0, n} << 24;
    q = 64'(wide / {64'd0, d});
    if ((wide / {64'd0, d}) > 128'h7FFF_FFFF && !neg) return 32'h7FFF_FFFF;
    if ((wide / {64'd0, d}) > 128'h8000_0000 && neg) return 32'h8000_0000;
    r = neg ? -q : q;
    return r[31:0];
  endfunction

  function automatic tb_mi3_types_pkg::inverse_t invert(tb_mi3_types_pkg::matrix_t x);
    tb_mi3_types_pkg::inverse_t y;
    logic signed [63:0] a, b, c, d, e, f, g, h, k, det;
    logic signed [63:0] adj [9];
    a = x.m[0]; b = x.m[1]; c = x.m[2];
    d = x.m[3]; e = x.m[4]; f = x.m[5];
    g = x.m[6]; h = x.m[7]; k = x.m[8];
    adj[0] = e * k - h * f; adj[1] = c * h - b * k; adj[2] = b * f - c * e;
    adj[3] = f * g - d * k; adj[4] = a * k - c * g; adj[5] = d * c - a * f;
    adj[6] = d * h - g * e; adj[7] = g * b - a * h; adj[8] = a * e - d * b;
    det = a * (e * k - f * h) - b * (d * k - f * g) + c * (d * h - e * g);
    y.sing = (det == 0);
    y.det = det[48:0];
    for (int i = 0; i < 9; i++) y.inv[i] = y.sing ? 32'd0 : quotient_sat(adj[i], det);
    return y;
  endfunction

  initial begin
    in_ch.valid <= 1'b0;
    {in_ch.m00, in_ch.m01, in_ch.m02, in_ch.m10, in_ch.m11, in_ch.m12,
     in_ch.m20, in_ch.m21, in_ch.m22} <= '0;
    out_ch.ready <= 1'b0;
  end

  task automatic send_matrix(tb_mi3_types_pkg::matrix_t x);
    if (in_idle_en && $urandom_range(3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    {in_ch.m00, in_ch.m01, in_ch.m02} <= {x.m[0], x.m[1], x.m[2]};
    {in_ch.m10, in_ch.m11, in_ch.m12} <= {x.m[3], x.m[4], x.m[5]};
    {in_ch.m20, in_ch.m21, in_ch.m22} <= {x.m[6], x.m[7], x.m[8]};
    do @(posedge clk_i); while (!in_ch.ready);
    expected_q.push_back(invert(x));
  endtask

  task automatic release_input();
    in_ch.valid <= 1'b0;
  endtask

  // Output stall generator: random bursts with out_ch.ready held low.
  initial begin
    int burst;
    burst = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (burst > 0) begin
        burst--;
        out_ch.ready <= 1'b0;
      end else if (out_stall_en && $urandom_range(4) == 0) begin
        burst = $urandom_range(0, 6);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  function automatic void compare_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %h actual %h", $time, name, want, got);
      n_errors++;
    end
  endfunction

  always @(posedge clk_i) begin
    tb_mi3_types_pkg::inverse_t want;
    logic signed [31:0] got [9];
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.inv00, out_ch.inv01, out_ch.inv02, out_ch.inv10, out_ch.inv11,
              out_ch.inv12, out_ch.inv20, out_ch.inv21, out_ch.inv22};
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected beat, expected none actual det %h", $time,
                 out_ch.determinant);
        n_errors++;
      end else begin
        want = expected_q.pop_front();
        for (int i = 0; i < 9; i++)
          compare_field($sformatf("inv%0d%0d", i / 3, i % 3), 64'(want.inv[i]), 64'(got[i]));
        compare_field("determinant", 64'(want.det), 64'(out_ch.determinant));
        compare_field("singular", 64'(want.sing), 64'(out_ch.singular));
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("matrix_inverse_3x3: mismatch");
      $finish;
    end
  end

  function automatic tb_mi3_types_pkg::matrix_t rand_matrix(int mode);
    tb_mi3_types_pkg::matrix_t x;
    for (int i = 0; i < 9; i++)
      case (mode)
        0: x.m[i] = 16'($urandom);
        1: x.m[i] = 16'($signed($urandom_range(0, 1024)) - 512);
        default: x.m[i] = 16'($signed($urandom_range(0, 64)) - 32);
      endcase
    return x;
  endfunction

  function automatic tb_mi3_types_pkg::matrix_t diag(logic signed [15:0] v);
    tb_mi3_types_pkg::matrix_t x;
    for (int i = 0; i < 9; i++) x.m[i] = (i % 4 == 0) ? v : 16'sd0;
    return x;
  endfunction

  task automatic wait_drained();
    while (expected_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_extremes();
    tb_mi3_types_pkg::matrix_t x;
    send_matrix(diag(16'sh0100));
    send_matrix(diag(16'sh7FFF));
    send_matrix(diag(-16'sh8000));
    send_matrix(diag(16'sh0001));
    send_matrix(diag(-16'sh0001));
    for (int i = 0; i < 9; i++) x.m[i] = 16'sh7FFF;
    send_matrix(x);
    for (int i = 0; i < 9; i++) x.m[i] = -16'sh8000;
    send_matrix(x);
    x = diag(-16'sh8000); x.m[1] = 16'sh7FFF; x.m[5] = 16'sh7FFF; x.m[6] = 16'sh7FFF;
    send_matrix(x);
    x = diag(16'sh7FFF); x.m[2] = -16'sh8000; x.m[3] = -16'sh8000; x.m[7] = 16'sh0001;
    send_matrix(x);
  endtask

  task automatic test_singular();
    tb_mi3_types_pkg::matrix_t x;
    send_matrix(diag(16'sh0000));
    x = rand_matrix(0);
    x.m[3] = x.m[0]; x.m[4] = x.m[1]; x.m[5] = x.m[2];
    send_matrix(x);
    x = rand_matrix(1);
    x.m[2] = x.m[0]; x.m[5] = x.m[3]; x.m[8] = x.m[6];
    send_matrix(x);
  endtask

  task automatic test_saturation();
    tb_mi3_types_pkg::matrix_t x;
    send_matrix(diag(16'sh0001));
    x = diag(16'sh0001); x.m[1] = 16'sh7FFF;
    send_matrix(x);
    x = diag(-16'sh0001); x.m[2] = -16'sh8000;
    send_matrix(x);
    x = diag(16'sh0002); x.m[8] = -16'sh0001; x.m[5] = 16'sh7000;
    send_matrix(x);
  endtask

  task automatic test_random(int count);
    for (int n = 0; n < count; n++) send_matrix(rand_matrix($urandom_range(0, 2)));
  endtask

  task automatic test_drain_pause();
    release_input();
    wait_drained();
    test_random(20);
  endtask

  task automatic test_full_rate(int count);
    in_idle_en = 1'b0;
    out_stall_en = 1'b0;
    test_random(count);
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_extremes();
    test_singular();
    test_saturation();
    test_random(350);
    test_drain_pause();
    test_random(200);
    test_full_rate(130);
    release_input();
    wait_drained();
    repeat (LATENCY + 10) @(posedge clk_i);
    if (n_errors == 0) begin
      $display("matrix_inverse_3x3: match");
    end else begin
      $display("matrix_inverse_3x3: mismatch");
    end
    $finish;
  end
endmodule
